### rtl/shreg_pkg.sv
`default_nettype none
package shreg_pkg;

	// Fixed field widths of the request and result channels
	localparam int KEY_W       = 64;
	localparam int FIELD_W     = 16;

	// Default table geometry
	localparam int DEF_TABLE_SLOTS = 64;
	localparam int DEF_HANDLE_BITS = 16;

	// Most entries one release request may free
	localparam int RESULT_LIMIT = 64;
	localparam int LIM_W        = $clog2(RESULT_LIMIT + 1);

	// Request kinds
	typedef enum logic [1:0] {
		REQ_REGISTER   = 2'd0,
		REQ_CLAIM      = 2'd1,
		REQ_UNREGISTER = 2'd2,
		REQ_RELEASE    = 2'd3
	} req_kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_ARG   = 2'd3
	} res_status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_BAD
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic init_step;
		logic scan_step;
		logic emit_bad;
		logic emit_end;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic init_last;
		logic go;
		logic args_bad;
		logic more;
		logic valid_s1;
		logic hit;
		logic is_release;
		logic limit_hit;
	} ctl_sts_t;

endpackage
`default_nettype wire

### rtl/share_handle_registry.sv
// Scan: a request scans the table one slot a cycle while no result is stalled; each slot is
// read into stage one, compared there, and a decided result is registered at the output.
// A release result is held until the next hit or the end of the scan.
// Requests are served one at a time, the scan paced by the single read port of the slot
// store; a stalled result pauses the scan.
// Reset: clears control state, then sweeps the table writing every slot free,
// with req_stall high, before the first request is taken. The id counter resets to one.
`default_nettype none
module share_handle_registry #(
	parameter int TABLE_SLOTS = shreg_pkg::DEF_TABLE_SLOTS,
	parameter int HANDLE_BITS = shreg_pkg::DEF_HANDLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [shreg_pkg::FIELD_W-1:0] owner_handle,
	input  wire logic [shreg_pkg::FIELD_W-1:0] region_handle,
	input  wire logic [shreg_pkg::KEY_W-1:0]   share_key,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         status,
	output logic [shreg_pkg::KEY_W-1:0]        minted_key,
	output logic [shreg_pkg::FIELD_W-1:0]      freed_region,
	output logic                               last_result
);

	shreg_pkg::ctl_cmd_t cmd;
	shreg_pkg::ctl_sts_t sts;

	// Sequence each request
	shreg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the table, scan it and form results
	shreg_datapath #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.owner_handle  (owner_handle),
		.region_handle (region_handle),
		.share_key     (share_key),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.status        (status),
		.minted_key    (minted_key),
		.freed_region  (freed_region),
		.last_result   (last_result)
	);

endmodule
`default_nettype wire

### rtl/shreg_ctrl.sv
`default_nettype none
module shreg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire shreg_pkg::ctl_sts_t  sts,
	output shreg_pkg::ctl_cmd_t       cmd
);

	shreg_pkg::ctl_state_t state_q, state_d;

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shreg_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Work out next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			shreg_pkg::S_INIT: begin
				if (sts.init_last) begin
					state_d = shreg_pkg::S_IDLE;
				end
			end
			shreg_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sts.args_bad ? shreg_pkg::S_BAD : shreg_pkg::S_SCAN;
				end
			end
			shreg_pkg::S_SCAN: begin
				if (sts.go) begin
					if (sts.hit && !sts.is_release) begin
						state_d = shreg_pkg::S_IDLE;
					end else if (sts.hit && sts.limit_hit) begin
						state_d = shreg_pkg::S_FINISH;
					end else if (!sts.more && !sts.valid_s1) begin
						state_d = shreg_pkg::S_FINISH;
					end
				end
			end
			shreg_pkg::S_FINISH, shreg_pkg::S_BAD: begin
				if (sts.go) begin
					state_d = shreg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = shreg_pkg::S_IDLE;
			end
		endcase
	end

	// Drive commands
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			shreg_pkg::S_INIT: begin
				cmd.init_step = 1'b1;
			end
			shreg_pkg::S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			shreg_pkg::S_SCAN: begin
				cmd.scan_step = sts.go;
			end
			shreg_pkg::S_FINISH: begin
				cmd.emit_end = sts.go;
			end
			shreg_pkg::S_BAD: begin
				cmd.emit_bad = sts.go;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/shreg_datapath.sv
`default_nettype none
module shreg_datapath #(
	parameter int TABLE_SLOTS = shreg_pkg::DEF_TABLE_SLOTS,
	parameter int HANDLE_BITS = shreg_pkg::DEF_HANDLE_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire shreg_pkg::ctl_cmd_t                  cmd,
	output shreg_pkg::ctl_sts_t                       sts,
	input  wire logic [1:0]                           req_type,
	input  wire logic [shreg_pkg::FIELD_W-1:0]        owner_handle,
	input  wire logic [shreg_pkg::FIELD_W-1:0]        region_handle,
	input  wire logic [shreg_pkg::KEY_W-1:0]          share_key,
	input  wire logic                                 res_stall,
	output logic                                      res_valid,
	output logic [1:0]                                status,
	output logic [shreg_pkg::KEY_W-1:0]               minted_key,
	output logic [shreg_pkg::FIELD_W-1:0]             freed_region,
	output logic                                      last_result
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int HW    = HANDLE_BITS;
	localparam int CW    = (HANDLE_BITS < shreg_pkg::FIELD_W) ? HANDLE_BITS : shreg_pkg::FIELD_W;
	localparam int KW    = shreg_pkg::KEY_W;
	localparam int LW    = shreg_pkg::LIM_W;

	// Slot stores
	logic [KW-1:0] key_mem    [TABLE_SLOTS];
	logic [HW-1:0] owner_mem  [TABLE_SLOTS];
	logic [HW-1:0] region_mem [TABLE_SLOTS];

	// Request registers
	shreg_pkg::req_kind_t req_type_q;
	logic [HW-1:0]        req_owner_q;
	logic [HW-1:0]        req_region_q;
	logic [KW-1:0]        req_key_q;

	// Scan state
	logic [CNT_W-1:0] addr_q;
	logic             valid_s1;
	logic [KW-1:0]    key_s1;
	logic [HW-1:0]    owner_s1;
	logic [HW-1:0]    region_s1;
	logic [IDX_W-1:0] slot_s1;
	logic [KW-1:0]    next_key_q;
	logic [KW-1:0]    next_key_inc;
	logic [LW-1:0]    rel_cnt_q;
	logic             pend_valid_q;
	logic [HW-1:0]    pend_region_q;

	// Output register
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [KW-1:0]               minted_key_q;
	logic [shreg_pkg::FIELD_W-1:0] freed_region_q;
	logic                        last_q;

	logic [HW-1:0] owner_in;
	logic [HW-1:0] region_in;
	logic          args_bad;
	logic          more;
	logic          match;
	logic          hit;
	logic          go;
	logic          limit_hit;
	logic          is_register;

	logic             wr_en;
	logic             wr_meta;
	logic [IDX_W-1:0] wr_idx;
	logic [KW-1:0]    wr_key;

	logic                   emit;
	shreg_pkg::res_status_t e_status;
	logic [KW-1:0]          e_key;
	logic [HW-1:0]          e_region;
	logic                   e_last;
	logic [shreg_pkg::FIELD_W-1:0] e_region_out;

	// Keep handles to their low bits
	always_comb begin
		owner_in  = '0;
		region_in = '0;
		owner_in[CW-1:0]  = owner_handle[CW-1:0];
		region_in[CW-1:0] = region_handle[CW-1:0];
	end

	// Check for null arguments on the incoming request
	always_comb begin
		case (shreg_pkg::req_kind_t'(req_type))
			shreg_pkg::REQ_REGISTER:   args_bad = (owner_in == '0) || (region_in == '0);
			shreg_pkg::REQ_CLAIM:      args_bad = (share_key == '0);
			shreg_pkg::REQ_UNREGISTER: args_bad = (share_key == '0) || (owner_in == '0);
			shreg_pkg::REQ_RELEASE:    args_bad = (owner_in == '0);
			default:                   args_bad = 1'b1;
		endcase
	end

	assign more        = (addr_q < CNT_W'(TABLE_SLOTS));
	assign go          = !out_valid_q || !res_stall;
	assign is_register = (req_type_q == shreg_pkg::REQ_REGISTER);
	assign limit_hit   = (rel_cnt_q == LW'(shreg_pkg::RESULT_LIMIT - 1));
	assign next_key_inc = next_key_q + KW'(1);

	// Compare the slot in stage one against the request
	always_comb begin
		case (req_type_q)
			shreg_pkg::REQ_REGISTER:   match = (key_s1 == '0);
			shreg_pkg::REQ_CLAIM:      match = (key_s1 == req_key_q);
			shreg_pkg::REQ_UNREGISTER: match = (key_s1 == req_key_q) && (owner_s1 == req_owner_q);
			shreg_pkg::REQ_RELEASE:    match = (key_s1 != '0) && (owner_s1 == req_owner_q);
			default:                   match = 1'b0;
		endcase
	end
	assign hit = valid_s1 && match;

	// Select the slot write
	always_comb begin
		wr_en   = 1'b0;
		wr_meta = 1'b0;
		wr_idx  = slot_s1;
		wr_key  = '0;
		if (cmd.init_step) begin
			wr_en  = 1'b1;
			wr_idx = addr_q[IDX_W-1:0];
		end else if (cmd.scan_step && hit) begin
			wr_en   = 1'b1;
			wr_meta = is_register;
			wr_key  = is_register ? next_key_q : '0;
		end
	end

	// Select the result to emit
	always_comb begin
		emit     = 1'b0;
		e_status = shreg_pkg::ST_OK;
		e_key    = '0;
		e_region = '0;
		e_last   = 1'b1;
		if (cmd.emit_bad) begin
			emit     = 1'b1;
			e_status = shreg_pkg::ST_BAD_ARG;
		end else if (cmd.emit_end) begin
			emit = 1'b1;
			case (req_type_q)
				shreg_pkg::REQ_REGISTER: begin
					e_status = shreg_pkg::ST_FULL;
				end
				shreg_pkg::REQ_RELEASE: begin
					if (pend_valid_q) begin
						e_region = pend_region_q;
					end else begin
						e_status = shreg_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					e_status = shreg_pkg::ST_NOT_FOUND;
				end
			endcase
		end else if (cmd.scan_step && hit) begin
			case (req_type_q)
				shreg_pkg::REQ_REGISTER: begin
					emit  = 1'b1;
					e_key = next_key_q;
				end
				shreg_pkg::REQ_RELEASE: begin
					emit     = pend_valid_q;
					e_region = pend_region_q;
					e_last   = 1'b0;
				end
				default: begin
					emit     = 1'b1;
					e_region = region_s1;
				end
			endcase
		end
	end

	// Mask the returned region to the narrower of the handle and field widths
	always_comb begin
		e_region_out = '0;
		e_region_out[CW-1:0] = e_region[CW-1:0];
	end

	// Write and read the slot stores
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= wr_key;
		end
		if (wr_meta) begin
			owner_mem[wr_idx]  <= req_owner_q;
			region_mem[wr_idx] <= req_region_q;
		end
		if (cmd.scan_step) begin
			key_s1    <= key_mem[addr_q[IDX_W-1:0]];
			owner_s1  <= owner_mem[addr_q[IDX_W-1:0]];
			region_s1 <= region_mem[addr_q[IDX_W-1:0]];
			slot_s1   <= addr_q[IDX_W-1:0];
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q   <= shreg_pkg::req_kind_t'(req_type);
			req_owner_q  <= owner_in;
			req_region_q <= region_in;
			req_key_q    <= share_key;
		end
	end

	// Advance scan control and the id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			valid_s1     <= 1'b0;
			next_key_q   <= KW'(1);
			rel_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				addr_q       <= '0;
				valid_s1     <= 1'b0;
				rel_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.init_step) begin
				addr_q <= addr_q + CNT_W'(1);
			end else if (cmd.scan_step) begin
				valid_s1 <= more;
				if (more) begin
					addr_q <= addr_q + CNT_W'(1);
				end
				if (hit && is_register) begin
					next_key_q <= (next_key_inc == '0) ? KW'(1) : next_key_inc;
				end
				if (hit && (req_type_q == shreg_pkg::REQ_RELEASE)) begin
					pend_valid_q <= 1'b1;
					rel_cnt_q    <= rel_cnt_q + LW'(1);
				end
			end
		end
	end

	// Hold the pending release region
	always_ff @(posedge clk) begin
		if (cmd.scan_step && hit) begin
			pend_region_q <= region_s1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q       <= e_status;
			minted_key_q   <= e_key;
			freed_region_q <= e_region_out;
			last_q         <= e_last;
		end
	end

	assign res_valid    = out_valid_q;
	assign status       = status_q;
	assign minted_key   = minted_key_q;
	assign freed_region = freed_region_q;
	assign last_result  = last_q;

	// Report status to the controller
	always_comb begin
		sts            = '0;
		sts.init_last  = (addr_q[IDX_W-1:0] == IDX_W'(TABLE_SLOTS - 1));
		sts.go         = go;
		sts.args_bad   = args_bad;
		sts.more       = more;
		sts.valid_s1   = valid_s1;
		sts.hit        = hit;
		sts.is_release = (req_type_q == shreg_pkg::REQ_RELEASE);
		sts.limit_hit  = limit_hit;
	end

endmodule
`default_nettype wire
